// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and character constants for the binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam logic [7:0] CharMinus   = 8'd45;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam int         DigitBits   = 4;
  localparam int         BitsPerStep = 4;

  typedef enum logic [1:0] {
    BkIdle,
    BkConv,
    BkSkip,
    BkEmit
  } bk_state_e;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } out_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } q_ctrl_t;

endpackage

// ===== rtl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a binary word, signed or unsigned, to decimal ASCII characters.
// ----------------------------------------------------------------------------
// Input channel: push / full with cmd_i (0 signed, 1 unsigned) and value_i.
// An item is taken on a rising edge with push high and full low.
// Result channel: empty / pop with ascii_char_o and last_o. The oldest
// character sits on the ports while empty is low; pop takes it. Each item
// gives an optional '-' then its digits, most significant first, with
// last_o high on the final digit. Zero gives a single '0'.
// The front end forms sign and magnitude and writes a two-entry queue; the
// back end reads it, runs a shift-add-three loop four bits per cycle, skips
// leading zeros one digit per cycle and emits one character per cycle when
// the receiver is not stalling. Per item, the back end loads the entry, runs
// the conversion, skips each leading zero, leaves the skip, then emits each
// digit; with no stall, the '-' goes out during the conversion.
// Reset empties the queue and the output register. A stalled receiver holds
// the back end; the queue keeps taking up to two further items.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            ascii_char_o,
  output logic                  last_o
);

  logic                q_wr;
  logic [DATA_WIDTH:0] q_wdata;
  logic                q_rd;
  logic [DATA_WIDTH:0] q_rdata;
  q_ctrl_t             q_ctrl;
  logic                out_valid;
  out_t                out_data;

  // front end: sign classification and magnitude
  b2da_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .push      (push),
    .full      (full),
    .cmd_i     (cmd_i),
    .value_i   (value_i),
    .q_full_i  (q_ctrl.full),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata)
  );

  // decoupling queue: sign flag over magnitude
  b2da_queue #(
    .WIDTH(DATA_WIDTH + 1)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .ctrl_o  (q_ctrl)
  );

  // back end: conversion and character output
  b2da_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_ctrl.empty),
    .q_rdata_i   (q_rdata),
    .q_rd_o      (q_rd),
    .out_valid_o (out_valid),
    .out_o       (out_data),
    .out_pop_i   (pop)
  );

  assign empty        = !out_valid;
  assign ascii_char_o = out_data.ascii_char;
  assign last_o       = out_data.last;

`ifndef ASSERT_OFF
  // the sign never closes a number
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && ascii_char_o == CharMinus |-> !last_o)
    else $error("minus character flagged as last");

  // the queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_ctrl.full && q_ctrl.empty))
    else $error("queue both full and empty");

  // front end writes only into a free entry
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctrl.push |-> !q_ctrl.full)
    else $error("queue written while full");

  // back end reads only a waiting entry
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctrl.pop |-> !q_ctrl.empty)
    else $error("queue read while empty");

  // a character that follows the sign is always a digit
  a_digit_after_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && ascii_char_o == CharMinus ##1 !empty |->
      ascii_char_o != CharMinus)
    else $error("two sign characters in a row");
`endif

endmodule

// ===== rtl/b2da_front.sv =====
// ----------------------------------------------------------------------------
// b2da_front
// Accepts items, classifies sign and forms the magnitude for the back end.
// ----------------------------------------------------------------------------
module b2da_front
  import b2da_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  push,
  output logic                  full,
  input  logic                  cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output logic [DATA_WIDTH:0]   q_wdata_o
);

  logic                  neg;
  logic [DATA_WIDTH-1:0] mag;

  // signed view only when the command asks for it and the top bit is set
  assign neg = !cmd_i && value_i[DATA_WIDTH-1];
  assign mag = neg ? (~value_i + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value_i;

  assign full      = q_full_i;
  assign q_wr_o    = push && !q_full_i;
  assign q_wdata_o = {neg, mag};

endmodule

// ===== rtl/b2da_queue.sv =====
// ----------------------------------------------------------------------------
// b2da_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module b2da_queue
  import b2da_pkg::*;
#(
  parameter int WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output q_ctrl_t          ctrl_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign ctrl_o.full  = (cnt_q == 2'd2);
  assign ctrl_o.empty = (cnt_q == 2'd0);
  assign ctrl_o.push  = wr_i;
  assign ctrl_o.pop   = rd_i;

  assign do_wr = wr_i && !ctrl_o.full;
  assign do_rd = rd_i && !ctrl_o.empty;

  always_comb begin
    wptr_d = do_wr ? !wptr_q : wptr_q;
    rptr_d = do_rd ? !rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];

endmodule

// ===== rtl/b2da_back.sv =====
// ----------------------------------------------------------------------------
// b2da_back
// Shift-add-three conversion, leading zero skip and character output register.
// ----------------------------------------------------------------------------
module b2da_back
  import b2da_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  logic [DATA_WIDTH:0] q_rdata_i,
  output logic                q_rd_o,
  output logic                out_valid_o,
  output out_t                out_o,
  input  logic                out_pop_i
);

  localparam int PW    = ((DATA_WIDTH + BitsPerStep - 1) / BitsPerStep) * BitsPerStep;
  localparam int NSTEP = PW / BitsPerStep;
  localparam int NDIG  = ((DATA_WIDTH * 1233) / 4096) + 1;
  localparam int BW    = NDIG * DigitBits;
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int RW    = $clog2(NDIG + 1);

  bk_state_e      state_q, state_d;
  logic [PW-1:0]  bin_q, bin_d;
  logic [BW-1:0]  bcd_q, bcd_d;
  logic [SW-1:0]  step_q, step_d;
  logic [RW-1:0]  rem_q, rem_d;
  logic           minus_q, minus_d;
  logic           oval_q, oval_d;
  out_t           out_q, out_d;
  logic           out_free;
  logic [PW-1:0]  bin_v;
  logic [BW-1:0]  bcd_v;
  logic [3:0]     top_dig;

  assign out_free = !oval_q || out_pop_i;
  assign top_dig  = bcd_q[BW-1 -: DigitBits];

  // four dependent shift-add-three steps per cycle
  always_comb begin
    bin_v = bin_q;
    bcd_v = bcd_q;
    for (int b = 0; b < BitsPerStep; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_v[d*DigitBits +: DigitBits] >= 4'd5) begin
          bcd_v[d*DigitBits +: DigitBits] = bcd_v[d*DigitBits +: DigitBits] + 4'd3;
        end
      end
      bcd_v = {bcd_v[BW-2:0], bin_v[PW-1]};
      bin_v = {bin_v[PW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    step_d  = step_q;
    rem_d   = rem_q;
    minus_d = minus_q;
    oval_d  = oval_q && !out_pop_i;
    out_d   = out_q;
    q_rd_o  = 1'b0;

    // the sign goes out as soon as the output slot is free
    if (minus_q && out_free) begin
      oval_d           = 1'b1;
      out_d.ascii_char = CharMinus;
      out_d.last       = 1'b0;
      minus_d          = 1'b0;
    end

    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          q_rd_o  = 1'b1;
          minus_d = q_rdata_i[DATA_WIDTH];
          bin_d   = PW'(q_rdata_i[DATA_WIDTH-1:0]);
          bcd_d   = '0;
          step_d  = SW'(NSTEP - 1);
          state_d = BkConv;
        end
      end
      BkConv: begin
        bin_d = bin_v;
        bcd_d = bcd_v;
        if (step_q == '0) begin
          rem_d   = RW'(NDIG);
          state_d = BkSkip;
        end else begin
          step_d = step_q - SW'(1);
        end
      end
      BkSkip: begin
        if (top_dig == 4'd0 && rem_q != RW'(1)) begin
          bcd_d = {bcd_q[BW-DigitBits-1:0], {DigitBits{1'b0}}};
          rem_d = rem_q - RW'(1);
        end else begin
          state_d = BkEmit;
        end
      end
      BkEmit: begin
        if (!minus_q && out_free) begin
          oval_d           = 1'b1;
          out_d.ascii_char = CharZero + {4'd0, top_dig};
          out_d.last       = (rem_q == RW'(1));
          bcd_d            = {bcd_q[BW-DigitBits-1:0], {DigitBits{1'b0}}};
          rem_d            = rem_q - RW'(1);
          if (rem_q == RW'(1)) begin
            state_d = BkIdle;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      minus_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      minus_q <= minus_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_o       = out_q;

endmodule
